### rtl/core/lca_pkg.sv
// Shared types and constants for the binary-lifting LCA block.
package lca_pkg;

  // Fixed field widths of the item channels
  localparam int NODE_W = 10;
  localparam int PATH_W = 11;
  // Counter widths carried in the command (up to 16 levels, up to 10 reduce steps)
  localparam int LVL_W  = 4;
  localparam int K_W    = 4;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_RED   = 4'd2,
    OP_ADD   = 4'd3,
    OP_ADEP  = 4'd4,
    OP_FILL  = 4'd5,
    OP_QDA   = 4'd6,
    OP_QDB   = 4'd7,
    OP_SORT  = 4'd8,
    OP_LIFT  = 4'd9,
    OP_CHK   = 4'd10,
    OP_CLIMB = 4'd11,
    OP_ROOT  = 4'd12,
    OP_PSAME = 4'd13,
    OP_PROOT = 4'd14,
    OP_OUT   = 4'd15
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LVL_W-1:0] lvl;
    logic [K_W-1:0]   k;
  } cmd_t;

  typedef struct packed {
    logic eq;        // climbing nodes already equal after the lift
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

### rtl/core/lca_req_if.sv
// Request channel: add or query item.
interface lca_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lca_pkg::NODE_W-1:0] node_a;
  logic [lca_pkg::NODE_W-1:0] node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

### rtl/core/lca_rsp_if.sv
// Response channel: query result.
interface lca_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [lca_pkg::NODE_W-1:0] common_ancestor;
  logic [lca_pkg::PATH_W-1:0] path_length;

  modport source (output valid, common_ancestor, path_length, input ready);
  modport sink   (input valid, common_ancestor, path_length, output ready);
endinterface

### rtl/core/lca_ctrl.sv
// Sequencing state machine for add and query items.
module lca_ctrl #(
  parameter int LEVELS    = 10,
  parameter int RED_STEPS = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_action,
  output logic          req_ready,
  input  lca_pkg::sts_t sts,
  output lca_pkg::cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_RED   = 14'b00000000000010,
    S_ADD   = 14'b00000000000100,
    S_ADEP  = 14'b00000000001000,
    S_FILL  = 14'b00000000010000,
    S_QDA   = 14'b00000000100000,
    S_QDB   = 14'b00000001000000,
    S_SORT  = 14'b00000010000000,
    S_LIFT  = 14'b00000100000000,
    S_CHK   = 14'b00001000000000,
    S_CLIMB = 14'b00010000000000,
    S_ROOT  = 14'b00100000000000,
    S_PSEL  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  localparam logic [lca_pkg::LVL_W-1:0] LVL_LAST = lca_pkg::LVL_W'(LEVELS - 1);
  localparam logic [lca_pkg::K_W-1:0]   K_FIRST  =
    lca_pkg::K_W'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);

  state_t                    state, state_next;
  logic [lca_pkg::LVL_W-1:0] lvl, lvl_next;
  logic [lca_pkg::K_W-1:0]   kcnt, kcnt_next;
  logic                      query, query_next;
  logic                      psel_root, psel_root_next;

  assign req_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    kcnt_next      = kcnt;
    query_next     = query;
    psel_root_next = psel_root;
    cmd.op         = lca_pkg::OP_NONE;
    cmd.lvl        = lvl;
    cmd.k          = kcnt;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = lca_pkg::OP_LOAD;
          query_next = req_action;
          kcnt_next  = K_FIRST;
          if (RED_STEPS > 0) state_next = S_RED;
          else state_next = req_action ? S_QDA : S_ADD;
        end
      end
      S_RED: begin
        cmd.op = lca_pkg::OP_RED;
        if (kcnt == '0) state_next = query ? S_QDA : S_ADD;
        else kcnt_next = kcnt - 1'b1;
      end
      S_ADD: begin
        cmd.op     = lca_pkg::OP_ADD;
        cmd.lvl    = '0;
        state_next = S_ADEP;
      end
      S_ADEP: begin
        cmd.op   = lca_pkg::OP_ADEP;
        lvl_next = lca_pkg::LVL_W'(1);
        state_next = (LEVELS > 1) ? S_FILL : S_IDLE;
      end
      S_FILL: begin
        cmd.op = lca_pkg::OP_FILL;
        if (lvl == LVL_LAST) state_next = S_IDLE;
        else lvl_next = lvl + 1'b1;
      end
      S_QDA: begin
        cmd.op     = lca_pkg::OP_QDA;
        state_next = S_QDB;
      end
      S_QDB: begin
        cmd.op     = lca_pkg::OP_QDB;
        state_next = S_SORT;
      end
      S_SORT: begin
        cmd.op     = lca_pkg::OP_SORT;
        lvl_next   = '0;
        state_next = S_LIFT;
      end
      S_LIFT: begin
        cmd.op = lca_pkg::OP_LIFT;
        if (lvl == LVL_LAST) state_next = S_CHK;
        else lvl_next = lvl + 1'b1;
      end
      S_CHK: begin
        cmd.op   = lca_pkg::OP_CHK;
        lvl_next = LVL_LAST;
        if (sts.eq) begin
          psel_root_next = 1'b0;
          state_next     = S_PSEL;
        end else begin
          state_next = S_CLIMB;
        end
      end
      S_CLIMB: begin
        cmd.op = lca_pkg::OP_CLIMB;
        if (lvl == '0) state_next = S_ROOT;
        else lvl_next = lvl - 1'b1;
      end
      S_ROOT: begin
        cmd.op         = lca_pkg::OP_ROOT;
        cmd.lvl        = '0;
        psel_root_next = 1'b1;
        state_next     = S_PSEL;
      end
      S_PSEL: begin
        cmd.op     = psel_root ? lca_pkg::OP_PROOT : lca_pkg::OP_PSAME;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.op = lca_pkg::OP_OUT;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= '0;
      kcnt      <= '0;
      query     <= 1'b0;
      psel_root <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      kcnt      <= kcnt_next;
      query     <= query_next;
      psel_root <= psel_root_next;
    end
  end

endmodule

### rtl/core/lca_dpath.sv
// Datapath: ancestor and depth tables, climb registers, result register.
module lca_dpath #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10,
  parameter int IW     = 10,
  parameter int LW     = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lca_pkg::cmd_t              cmd,
  output lca_pkg::sts_t              sts,
  input  logic [lca_pkg::NODE_W-1:0] node_a,
  input  logic [lca_pkg::NODE_W-1:0] node_b,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [lca_pkg::NODE_W-1:0] rsp_anc,
  output logic [lca_pkg::PATH_W-1:0] rsp_len
);

  localparam logic [lca_pkg::NODE_W-1:0] NODES_F = lca_pkg::NODE_W'(NODES);
  localparam logic [IW-1:0]              DMAX    = IW'(NODES - 1);

  // Tables, undefined until written
  logic [IW-1:0] anc_mem [NODES][LEVELS];
  logic [IW-1:0] dep_mem [NODES];

  logic [lca_pkg::NODE_W-1:0] a_reg, b_reg, sub_k;
  logic [IW-1:0]              ia, ib;
  logic [IW-1:0]              u_reg, v_reg, da, db, p_reg;
  logic [IW-1:0]              ard_a, ard_b, drd;
  logic [LEVELS-1:0]          diff;
  logic                       pend;
  logic [LW-1:0]              lvl_i;

  logic [IW-1:0] v_lift, u_c, v_c, dep_gap;
  logic          take;

  // Memory port controls
  logic          anc_we, ra_en, rb_en, fwd;
  logic [IW-1:0] w_node, w_data, ra_node, rb_node;
  logic          d_we, d_re;
  logic [IW-1:0] d_waddr, d_wdata, d_raddr;

  logic [IW+1:0] len_sum, len_sub;

  assign ia    = IW'(a_reg);
  assign ib    = IW'(b_reg);
  assign lvl_i = cmd.lvl[LW-1:0];
  assign sub_k = NODES_F << cmd.k;

  // Climb operand selection: use last read data when it is pending
  assign v_lift  = pend ? ard_a : v_reg;
  assign take    = pend && (ard_a != ard_b);
  assign u_c     = take ? ard_a : u_reg;
  assign v_c     = take ? ard_b : v_reg;
  assign dep_gap = (da > drd) ? (da - drd) : (drd - da);

  assign sts.eq       = (u_reg == v_lift);
  assign sts.out_free = !rsp_valid || rsp_ready;

  // Table access decode
  always_comb begin
    anc_we  = 1'b0;
    w_node  = ia;
    w_data  = ard_a;
    ra_en   = 1'b0;
    ra_node = ard_a;
    rb_en   = 1'b0;
    rb_node = v_c;
    d_we    = 1'b0;
    d_waddr = ia;
    d_wdata = '0;
    d_re    = 1'b0;
    d_raddr = ia;
    unique case (cmd.op)
      lca_pkg::OP_ADD: begin
        anc_we  = 1'b1;
        w_data  = ib;
        ra_en   = 1'b1;
        ra_node = ib;
        d_re    = 1'b1;
        d_raddr = ib;
      end
      lca_pkg::OP_ADEP: begin
        d_we = 1'b1;
        if (ia == ib) d_wdata = '0;
        else if (drd >= DMAX) d_wdata = DMAX;
        else d_wdata = drd + 1'b1;
      end
      lca_pkg::OP_FILL: begin
        anc_we = 1'b1;
        ra_en  = 1'b1;
      end
      lca_pkg::OP_QDA: begin
        d_re = 1'b1;
      end
      lca_pkg::OP_QDB: begin
        d_re    = 1'b1;
        d_raddr = ib;
      end
      lca_pkg::OP_LIFT: begin
        ra_en   = diff[0];
        ra_node = v_lift;
      end
      lca_pkg::OP_CLIMB: begin
        ra_en   = 1'b1;
        ra_node = u_c;
        rb_en   = 1'b1;
      end
      lca_pkg::OP_ROOT: begin
        ra_en   = 1'b1;
        ra_node = u_c;
      end
      lca_pkg::OP_PSAME: begin
        d_re    = 1'b1;
        d_raddr = u_reg;
      end
      lca_pkg::OP_PROOT: begin
        d_re    = 1'b1;
        d_raddr = ard_a;
      end
      default: begin
      end
    endcase
  end

  // Same-cycle write and port-A read of one entry returns the new value
  assign fwd = anc_we && (w_node == ra_node);

  // Ancestor table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[w_node][lvl_i] <= w_data;
    if (ra_en)  ard_a <= fwd ? w_data : anc_mem[ra_node][lvl_i];
    if (rb_en)  ard_b <= anc_mem[rb_node][lvl_i];
  end

  // Depth table
  always_ff @(posedge clk) begin
    if (d_we) dep_mem[d_waddr] <= d_wdata;
    if (d_re) drd <= dep_mem[d_raddr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      lca_pkg::OP_LOAD: begin
        a_reg <= node_a;
        b_reg <= node_b;
      end
      lca_pkg::OP_RED: begin
        if (a_reg >= sub_k) a_reg <= a_reg - sub_k;
        if (b_reg >= sub_k) b_reg <= b_reg - sub_k;
      end
      lca_pkg::OP_QDB: begin
        da <= drd;
      end
      lca_pkg::OP_SORT: begin
        db   <= drd;
        pend <= 1'b0;
        diff <= LEVELS'(dep_gap);
        if (da > drd) begin
          u_reg <= ib;
          v_reg <= ia;
        end else begin
          u_reg <= ia;
          v_reg <= ib;
        end
      end
      lca_pkg::OP_LIFT: begin
        v_reg <= v_lift;
        pend  <= diff[0];
        diff  <= diff >> 1;
      end
      lca_pkg::OP_CHK: begin
        v_reg <= v_lift;
        pend  <= 1'b0;
      end
      lca_pkg::OP_CLIMB: begin
        u_reg <= u_c;
        v_reg <= v_c;
        pend  <= 1'b1;
      end
      lca_pkg::OP_PSAME: begin
        p_reg <= u_reg;
      end
      lca_pkg::OP_PROOT: begin
        p_reg <= ard_a;
      end
      default: begin
      end
    endcase
  end

  // Path length: depth_a + depth_b - 2 * depth_lca, clamped at zero
  assign len_sum = {2'b00, da} + {2'b00, db};
  assign len_sub = {1'b0, drd, 1'b0};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == lca_pkg::OP_OUT && sts.out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lca_pkg::OP_OUT && sts.out_free) begin
      rsp_anc <= lca_pkg::NODE_W'(p_reg);
      if (len_sum < len_sub) rsp_len <= '0;
      else rsp_len <= lca_pkg::PATH_W'(len_sum - len_sub);
    end
  end

endmodule

### rtl/core/tree_lca_binary_lifting.sv
// Add item: index reduction, parent write, depth write, upper-level fill; no result.
// Query: depth reads, sort, lift, check, climb down the levels, root step, select, output;
// climb and root are skipped when one node lifts onto the other; items run one at a time.
// The index reduction step count is zero for NODES >= 1024, else log2(1023/NODES)+1.
// A request is taken while a finished result still waits in the output register.
// Reset clears control only; table contents are undefined until written, no clearing pass.
module tree_lca_binary_lifting #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic            clk,
  input  logic            rst,
  lca_req_if.sink         req,
  lca_rsp_if.source       rsp
);

  localparam int IW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int RQ        = 1023 / NODES;
  localparam int RED_STEPS = (RQ == 0) ? 0 : $clog2(RQ + 1);

  lca_pkg::cmd_t cmd;
  lca_pkg::sts_t sts;

  lca_ctrl #(
    .LEVELS    (LEVELS),
    .RED_STEPS (RED_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lca_dpath #(
    .NODES  (NODES),
    .LEVELS (LEVELS),
    .IW     (IW),
    .LW     (LW)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .node_a    (req.node_a),
    .node_b    (req.node_b),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_anc   (rsp.common_ancestor),
    .rsp_len   (rsp.path_length)
  );

  // A result appears only from the output step of a query
  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.op == lca_pkg::OP_OUT))
    else $error("response raised outside output step");

  // Every transfer starts multi-cycle work
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request ready right after transfer");

  // Row fill never targets level zero or runs past the last level
  a_fill_level: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == lca_pkg::OP_FILL) |-> (cmd.lvl != '0 && cmd.lvl < LEVELS))
    else $error("fill level out of range");

  // Climb stays within the table levels
  a_climb_level: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == lca_pkg::OP_CLIMB || cmd.op == lca_pkg::OP_LIFT) |-> (cmd.lvl < LEVELS))
    else $error("climb level out of range");

endmodule
